[rtl/npcl1_pkg.sv]
// Shared types and constants for the nearest palette color block.
// No dependencies; used by the search cell, the top level and the port checker.
`timescale 1ns / 1ps

package npcl1_pkg;

    // Widths fixed by the item format.
    localparam int COLOR_W = 32;
    localparam int DIST_W  = 10;
    localparam int SLOT_W  = 8;

    // Command codes carried in s_tuser.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_MATCH = 1'b1;

    // Largest possible RGB Manhattan distance.
    localparam logic [DIST_W-1:0] DIST_MAX = 10'd765;

    // Search request traveling down the chain of cells, with the best entry so far.
    typedef struct packed {
        logic               valid;
        logic [COLOR_W-1:0] pixel;
        logic [DIST_W-1:0]  best_dist;
        logic [COLOR_W-1:0] color;
    } npcl1_token_t;

endpackage

[rtl/npcl1_cell.sv]
// One cell of the palette search chain: holds one palette entry and compares it
// against the request passing through. Depends on npcl1_pkg.
`timescale 1ns / 1ps

module npcl1_cell import npcl1_pkg::*; #(
    parameter int IDX   = 0,
    parameter int IDX_W = 8,
    parameter int LIM_W = 9
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic [LIM_W-1:0]   limit,
    input  logic               wr_en,
    input  logic [COLOR_W-1:0] wr_color,
    input  npcl1_token_t       tok_in,
    input  logic [IDX_W-1:0]   idx_in,
    output npcl1_token_t       tok_out,
    output logic [IDX_W-1:0]   idx_out
);

    localparam logic [LIM_W-1:0] MY_POS = LIM_W'(IDX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [COLOR_W-1:0] entry_reg;
    logic               valid_reg;
    logic [COLOR_W-1:0] pixel_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic [7:0]        diff_r;
    logic [7:0]        diff_g;
    logic [7:0]        diff_b;
    logic [DIST_W-1:0] dist_here;
    logic              in_range;
    logic              take;

    // Absolute difference of one 8-bit channel.
    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    // Palette entry storage, written by a load request addressed to this cell.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg <= wr_color;
        end
    end

    // Distance from the passing pixel to this entry, ignoring alpha.
    always_comb begin
        diff_r    = abs_diff(tok_in.pixel[23:16], entry_reg[23:16]);
        diff_g    = abs_diff(tok_in.pixel[15:8], entry_reg[15:8]);
        diff_b    = abs_diff(tok_in.pixel[7:0], entry_reg[7:0]);
        dist_here = DIST_W'(diff_r) + DIST_W'(diff_g) + DIST_W'(diff_b);
        in_range  = MY_POS < limit;
        // The first cell always seeds the best; later cells win only on a strictly
        // smaller distance, so ties stay with the lower index.
        take      = (IDX == 0) || (in_range && (dist_here < tok_in.best_dist));
    end

    // Valid bit of the stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= tok_in.valid;
        end
    end

    // Payload of the stage.
    always_ff @(posedge aclk) begin
        if (en) begin
            pixel_reg <= tok_in.pixel;
            if (take) begin
                dist_reg  <= dist_here;
                color_reg <= entry_reg;
                idx_reg   <= MY_IDX;
            end else begin
                dist_reg  <= tok_in.best_dist;
                color_reg <= tok_in.color;
                idx_reg   <= idx_in;
            end
        end
    end

    assign tok_out.valid     = valid_reg;
    assign tok_out.pixel     = pixel_reg;
    assign tok_out.best_dist = dist_reg;
    assign tok_out.color     = color_reg;
    assign idx_out           = idx_reg;

endmodule

[rtl/nearest_palette_color_l1.sv]
// Nearest palette color by RGB Manhattan distance: top level with the cell chain,
// the configuration register and the result register. Depends on npcl1_pkg, npcl1_cell.
`timescale 1ns / 1ps

// The palette lives in a row of PALETTE_DEPTH cells, one entry per cell. A load
// request writes the cell named by its slot; slots at or above PALETTE_DEPTH are
// dropped. A match request enters the first cell and moves one cell per cycle
// while the chain is not stalled, each cell below palette_count keeping the closer
// of its own entry and the best so far, so the match reaches the result register
// with the closest entry of the first palette_count cells. One match is in flight
// at a time; the input is ready again as soon as the result reaches the output
// register, which holds it while the downstream side stalls. palette_count is
// saturated to the range 1 to PALETTE_DEPTH when written.
module nearest_palette_color_l1 import npcl1_pkg::*; #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel: palette_count.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    // Request input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [7:0] entry_index, [39:8] color
    input  logic        s_tuser,    // [0] cmd
    // Result output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata     // [31:0] matched_color, [39:32] matched_index,
                                    // [49:40] best_distance, [55:50] zero
);

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int LIM_W = $clog2(PALETTE_DEPTH + 1);
    localparam int CNT_W = (LIM_W > 9) ? LIM_W : 9;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

    logic [LIM_W-1:0] limit_reg;
    logic [CNT_W-1:0] cfg_ext;
    logic [LIM_W-1:0] limit_next;

    logic busy_reg;
    logic busy_next;

    logic               out_valid_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic [SLOT_W-1:0]  out_index_reg;
    logic [DIST_W-1:0]  out_dist_reg;

    logic                      s_req;
    logic                      load_req;
    logic                      match_req;
    logic [SLOT_W-1:0]         s_entry_index;
    logic [COLOR_W-1:0]        s_color;
    logic                      chain_en;
    logic                      result_move;
    logic [PALETTE_DEPTH-1:0]  wr_en;

    npcl1_token_t      chain_tok [0:PALETTE_DEPTH];
    logic [IDX_W-1:0]  chain_idx [0:PALETTE_DEPTH];

    // Unpack the request.
    assign s_entry_index = s_tdata[7:0];
    assign s_color       = s_tdata[39:8];
    assign s_tready      = !busy_reg;
    assign s_req         = s_tvalid && s_tready;
    assign load_req      = s_req && (s_tuser == CMD_LOAD);
    assign match_req     = s_req && (s_tuser == CMD_MATCH);

    // Configuration register, held as the saturated search limit.
    assign cfg_ready = 1'b1;
    always_comb begin
        cfg_ext = CNT_W'(cfg_data);
        if (cfg_ext == '0) begin
            limit_next = LIM_W'(1);
        end else if (cfg_ext > DEPTH_CNT) begin
            limit_next = LIM_W'(PALETTE_DEPTH);
        end else begin
            limit_next = LIM_W'(cfg_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIM_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= limit_next;
        end
    end

    // The chain only stalls when a result is ready to leave and the output is full.
    assign chain_en    = !(chain_tok[PALETTE_DEPTH].valid && out_valid_reg && !m_tready);
    assign result_move = chain_tok[PALETTE_DEPTH].valid && chain_en;

    // Busy from match acceptance until its result reaches the output register.
    always_comb begin
        busy_next = busy_reg;
        if (match_req) begin
            busy_next = 1'b1;
        end else if (result_move) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    // Request entering the first cell.
    assign chain_tok[0].valid     = match_req;
    assign chain_tok[0].pixel     = s_color;
    assign chain_tok[0].best_dist = '0;
    assign chain_tok[0].color     = '0;
    assign chain_idx[0]           = '0;

    // Row of cells; only the first 256 slots can be addressed by a load.
    for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
        if (i < 256) begin : g_wr
            assign wr_en[i] = load_req && (s_entry_index == SLOT_W'(i));
        end else begin : g_nowr
            assign wr_en[i] = 1'b0;
        end

        npcl1_cell #(
            .IDX   (i),
            .IDX_W (IDX_W),
            .LIM_W (LIM_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (chain_en),
            .limit    (limit_reg),
            .wr_en    (wr_en[i]),
            .wr_color (s_color),
            .tok_in   (chain_tok[i]),
            .idx_in   (chain_idx[i]),
            .tok_out  (chain_tok[i+1]),
            .idx_out  (chain_idx[i+1])
        );
    end

    // Output register valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (result_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (result_move) begin
            out_color_reg <= chain_tok[PALETTE_DEPTH].color;
            out_index_reg <= SLOT_W'(chain_idx[PALETTE_DEPTH]);
            out_dist_reg  <= chain_tok[PALETTE_DEPTH].best_dist;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_dist_reg, out_index_reg, out_color_reg};

endmodule

[rtl/npcl1_checker.sv]
// Port-level checker for nearest_palette_color_l1, attached by a bind statement.
// Depends on npcl1_pkg and the top level's port names.
`timescale 1ns / 1ps

module npcl1_checker import npcl1_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // A reported distance never exceeds the RGB maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[49:40] <= DIST_MAX))
        else $error("distance out of range");

    // An accepted match occupies the block for the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_MATCH)) |=> !s_tready)
        else $error("input ready right after a match request");

    // A load request never blocks the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_LOAD)) |=> s_tready)
        else $error("input blocked after a load request");

    // A new result appears together with the input becoming free again.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result appeared while a match is still in flight");

endmodule

bind nearest_palette_color_l1 npcl1_checker u_npcl1_checker (.*);
